@@ src/qsrpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsrpd_pkg: shared types and constants
// register indexes, event codes and status bundles of the presence detector
// ----------------------------------------------------------------------------
package qsrpd_pkg;

   localparam int RSSI_W = 8;
   localparam int TIME_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int GRID_SEL_W = 3;
   localparam int RUN_W = 8;
   localparam int MCAND_W = RSSI_W + 1;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_RSSI_THRESHOLD = 3'd0;
   localparam csr_index_type CSR_WINDOWS_TO_ABSENT = 3'd1;
   localparam csr_index_type CSR_WINDOWS_TO_PRESENT = 3'd2;
   localparam csr_index_type CSR_GRID_ROW = 3'd3;
   localparam csr_index_type CSR_GRID_COL = 3'd4;

   typedef logic [1:0] event_type;

   localparam event_type EV_NONE = 2'd0;
   localparam event_type EV_PRESENT = 2'd1;
   localparam event_type EV_ABSENT = 2'd2;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [RUN_W-1:0] RUN_LIMIT_MIN = 8'd2;

   // slot tracker view of the position that the next tick enters
   typedef struct packed {
      logic awake;
      logic wrap;
   } slot_stat_type;

   // shift-add multiplier status
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage
`default_nettype wire

@@ src/qsrpd_slot.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsrpd_slot: quorum grid slot tracker
// walks the grid row by row and flags slots in the chosen row or column
// ----------------------------------------------------------------------------
module qsrpd_slot #(
   parameter int GRID_SIDE = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    advance,
   input  wire logic [qsrpd_pkg::GRID_SEL_W-1:0]        grid_row,
   input  wire logic [qsrpd_pkg::GRID_SEL_W-1:0]        grid_col,
   output qsrpd_pkg::slot_stat_type                     stat
);

   localparam int GW = $clog2(GRID_SIDE);
   localparam int CMP_W = (GW > qsrpd_pkg::GRID_SEL_W) ? GW : qsrpd_pkg::GRID_SEL_W;
   localparam logic [GW-1:0] LAST = GW'(GRID_SIDE - 1);

   logic [GW-1:0] row_ff, row_in;
   logic [GW-1:0] col_ff, col_in;
   logic          col_wrap;

   // position after the next tick
   always_comb begin
      col_wrap = (col_ff == LAST);
      col_in = col_wrap ? '0 : col_ff + GW'(1);
      if (col_wrap) begin
         row_in = (row_ff == LAST) ? '0 : row_ff + GW'(1);
      end else begin
         row_in = row_ff;
      end
      stat.wrap = (row_in == '0) && (col_in == '0);
      stat.awake = (CMP_W'(row_in) == CMP_W'(grid_row)) ||
                   (CMP_W'(col_in) == CMP_W'(grid_col));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule
`default_nettype wire

@@ src/qsrpd_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsrpd_mul: iterative shift-add multiplier
// one adder, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module qsrpd_mul #(
   parameter int CNT_W = 10
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic signed [qsrpd_pkg::MCAND_W-1:0]     mcand,
   input  wire logic [CNT_W-1:0]                         mplier,
   output logic signed [CNT_W+qsrpd_pkg::MCAND_W:0]      product,
   output qsrpd_pkg::mul_stat_type                       stat
);

   localparam int PROD_W = CNT_W + qsrpd_pkg::MCAND_W + 1;
   localparam int STEP_W = $clog2(CNT_W + 1);

   logic signed [PROD_W-1:0]            acc_ff, acc_in;
   logic [CNT_W-1:0]                    mplier_ff, mplier_in;
   logic signed [qsrpd_pkg::MCAND_W-1:0] mcand_ff, mcand_in;
   logic [STEP_W-1:0]                   steps_ff, steps_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic signed [PROD_W-1:0]            addend;

   always_comb begin
      acc_in = acc_ff;
      mplier_in = mplier_ff;
      mcand_in = mcand_ff;
      steps_in = steps_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      addend = mplier_ff[CNT_W-1] ? PROD_W'(mcand_ff) : '0;
      if (start) begin
         acc_in = '0;
         mplier_in = mplier;
         mcand_in = mcand;
         steps_in = STEP_W'(CNT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + addend;
         mplier_in = mplier_ff << 1;
         steps_in = steps_ff - STEP_W'(1);
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         steps_ff <= steps_in;
      end
      acc_ff <= acc_in;
      mplier_ff <= mplier_in;
      mcand_ff <= mcand_in;
   end

   assign product = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

@@ src/quorum_slot_rssi_presence_detector_top.sv @@
`default_nettype none
// a sample or a tick that does not close a window is answered in the output register
//   in the cycle after its transfer; a tick that closes a window starts the
//   bit-serial multiplier that scales the threshold by the count, waits in ST_EVAL
//   for it to finish, then is answered from ST_DONE once the output slot is free
// throughput: one item per cycle while results drain; a window-closing tick holds the
//   input until answered; reset clears sequencer, window and valid state, loads defaults
// ----------------------------------------------------------------------------
// quorum_slot_rssi_presence_detector_top: quorum slot rssi presence detector
// window rssi averaging with consecutive-window presence hysteresis
// ----------------------------------------------------------------------------
module quorum_slot_rssi_presence_detector_top #(
   parameter int GRID_SIDE = 8,
   parameter int SAMPLE_COUNT_MAX = 1023
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // item channel
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic                                      req_cmd,
   input  wire logic signed [qsrpd_pkg::RSSI_W-1:0]       req_rssi,
   input  wire logic [qsrpd_pkg::TIME_W-1:0]              req_time_s,
   // result channel
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic                                           rsp_awake,
   output logic                                           rsp_window_done,
   output logic [1:0]                                     rsp_event_res,
   output logic [qsrpd_pkg::TIME_W-1:0]                   rsp_event_time,
   output logic                                           rsp_present,
   // register write channel
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [qsrpd_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [qsrpd_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int CNT_W = $clog2(SAMPLE_COUNT_MAX + 1);
   localparam int SUM_W = CNT_W + qsrpd_pkg::RSSI_W;
   localparam int PROD_W = CNT_W + qsrpd_pkg::MCAND_W + 1;
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(SAMPLE_COUNT_MAX);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // configuration registers
   logic signed [qsrpd_pkg::RSSI_W-1:0]      thr_ff, thr_in;
   logic [qsrpd_pkg::RUN_W-1:0]              to_absent_ff, to_absent_in;
   logic [qsrpd_pkg::RUN_W-1:0]              to_present_ff, to_present_in;
   logic [qsrpd_pkg::GRID_SEL_W-1:0]         row_ff, row_in;
   logic [qsrpd_pkg::GRID_SEL_W-1:0]         col_ff, col_in;

   // window and hysteresis state
   state_type                                state_ff, state_in;
   logic signed [SUM_W-1:0]                  sum_ff, sum_in;
   logic [CNT_W-1:0]                         count_ff, count_in;
   logic                                     presence_ff, presence_in;
   logic [qsrpd_pkg::RUN_W-1:0]              run_ff, run_in;
   logic [qsrpd_pkg::TIME_W-1:0]             run_start_ff, run_start_in;

   // closing tick held while the window is evaluated
   logic [qsrpd_pkg::TIME_W-1:0]             tick_time_ff, tick_time_in;
   logic                                     tick_awake_ff, tick_awake_in;

   // output register
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     awake_ff, awake_in;
   logic                                     done_ff, done_in;
   qsrpd_pkg::event_type                     event_ff, event_in;
   logic [qsrpd_pkg::TIME_W-1:0]             event_time_ff, event_time_in;
   logic                                     present_ff, present_in;

   logic                                     req_xfer;
   logic                                     out_free;
   logic                                     slot_advance;
   qsrpd_pkg::slot_stat_type                 slot_stat;
   logic                                     mul_start;
   logic signed [qsrpd_pkg::MCAND_W-1:0]     mcand;
   logic signed [PROD_W-1:0]                 product;
   qsrpd_pkg::mul_stat_type                  mul_stat;
   logic                                     detected;
   logic                                     extend;
   logic [qsrpd_pkg::RUN_W-1:0]              run_limit;
   logic [qsrpd_pkg::RUN_W-1:0]              run_next;

   assign csr_ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // a new item is taken only when the sequencer is idle and the output slot can be filled
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer = req_valid && req_ready;
   assign slot_advance = req_xfer && (req_cmd == qsrpd_pkg::CMD_TICK);

   qsrpd_slot #(
      .GRID_SIDE (GRID_SIDE)
   ) u_slot (
      .clock    (clock),
      .reset    (reset),
      .advance  (slot_advance),
      .grid_row (row_ff),
      .grid_col (col_ff),
      .stat     (slot_stat)
   );

   // trunc(sum/count) > thr  <=>  sum > thr*count       for thr < 0
   //                          <=>  sum >= (thr+1)*count  for thr >= 0
   assign mcand = thr_ff[qsrpd_pkg::RSSI_W-1] ? qsrpd_pkg::MCAND_W'(thr_ff) :
                  qsrpd_pkg::MCAND_W'(thr_ff) + qsrpd_pkg::MCAND_W'(1);

   qsrpd_mul #(
      .CNT_W (CNT_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mcand),
      .mplier  (count_ff),
      .product (product),
      .stat    (mul_stat)
   );

   always_comb begin
      if (count_ff == '0) begin
         detected = 1'b0;
      end else if (thr_ff[qsrpd_pkg::RSSI_W-1]) begin
         detected = PROD_W'(sum_ff) > product;
      end else begin
         detected = PROD_W'(sum_ff) >= product;
      end
      // a run grows on undetected windows while present, on detected ones while absent
      extend = presence_ff ? !detected : detected;
      if (presence_ff) begin
         run_limit = (to_absent_ff < qsrpd_pkg::RUN_LIMIT_MIN) ? qsrpd_pkg::RUN_LIMIT_MIN :
                     to_absent_ff;
      end else begin
         run_limit = (to_present_ff < qsrpd_pkg::RUN_LIMIT_MIN) ? qsrpd_pkg::RUN_LIMIT_MIN :
                     to_present_ff;
      end
      run_next = run_ff + qsrpd_pkg::RUN_W'(1);
   end

   // register writes
   always_comb begin
      thr_in = thr_ff;
      to_absent_in = to_absent_ff;
      to_present_in = to_present_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            qsrpd_pkg::CSR_RSSI_THRESHOLD: thr_in = csr_wdata;
            qsrpd_pkg::CSR_WINDOWS_TO_ABSENT: to_absent_in = csr_wdata;
            qsrpd_pkg::CSR_WINDOWS_TO_PRESENT: to_present_in = csr_wdata;
            qsrpd_pkg::CSR_GRID_ROW: row_in = csr_wdata[qsrpd_pkg::GRID_SEL_W-1:0];
            qsrpd_pkg::CSR_GRID_COL: col_in = csr_wdata[qsrpd_pkg::GRID_SEL_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      presence_in = presence_ff;
      run_in = run_ff;
      run_start_in = run_start_ff;
      tick_time_in = tick_time_ff;
      tick_awake_in = tick_awake_ff;
      mul_start = 1'b0;
      awake_in = awake_ff;
      done_in = done_ff;
      event_in = event_ff;
      event_time_in = event_time_ff;
      present_in = present_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == qsrpd_pkg::CMD_SAMPLE) begin
                  // samples past the count limit are dropped
                  if (count_ff < COUNT_MAX) begin
                     sum_in = sum_ff + SUM_W'(req_rssi);
                     count_in = count_ff + CNT_W'(1);
                  end
                  rsp_valid_in = 1'b1;
                  awake_in = 1'b0;
                  done_in = 1'b0;
                  event_in = qsrpd_pkg::EV_NONE;
                  event_time_in = '0;
                  present_in = presence_ff;
               end else if (slot_stat.wrap) begin
                  // window closes: scale the threshold by the count
                  mul_start = 1'b1;
                  tick_time_in = req_time_s;
                  tick_awake_in = slot_stat.awake;
                  state_in = ST_EVAL;
               end else begin
                  rsp_valid_in = 1'b1;
                  awake_in = slot_stat.awake;
                  done_in = 1'b0;
                  event_in = qsrpd_pkg::EV_NONE;
                  event_time_in = '0;
                  present_in = presence_ff;
               end
            end
         end
         ST_EVAL: begin
            if (mul_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               awake_in = tick_awake_ff;
               done_in = 1'b1;
               event_in = qsrpd_pkg::EV_NONE;
               event_time_in = '0;
               present_in = presence_ff;
               if (extend) begin
                  if (run_next == qsrpd_pkg::RUN_W'(1)) begin
                     run_in = run_next;
                     run_start_in = tick_time_ff;
                  end else if (run_next >= run_limit) begin
                     run_in = '0;
                     event_in = presence_ff ? qsrpd_pkg::EV_ABSENT : qsrpd_pkg::EV_PRESENT;
                     event_time_in = run_start_ff;
                     presence_in = !presence_ff;
                     present_in = !presence_ff;
                  end else begin
                     run_in = run_next;
                  end
               end else begin
                  run_in = '0;
               end
               sum_in = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= -8'sd65;
         to_absent_ff <= 8'd3;
         to_present_ff <= 8'd2;
         row_ff <= '0;
         col_ff <= '0;
         state_ff <= ST_IDLE;
         sum_ff <= '0;
         count_ff <= '0;
         presence_ff <= 1'b0;
         run_ff <= '0;
         run_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         to_absent_ff <= to_absent_in;
         to_present_ff <= to_present_in;
         row_ff <= row_in;
         col_ff <= col_in;
         state_ff <= state_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         presence_ff <= presence_in;
         run_ff <= run_in;
         run_start_ff <= run_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tick_time_ff <= tick_time_in;
      tick_awake_ff <= tick_awake_in;
      awake_ff <= awake_in;
      done_ff <= done_in;
      event_ff <= event_in;
      event_time_ff <= event_time_in;
      present_ff <= present_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_awake = awake_ff;
   assign rsp_window_done = done_ff;
   assign rsp_event_res = event_ff;
   assign rsp_event_time = event_time_ff;
   assign rsp_present = present_ff;

endmodule
`default_nettype wire

@@ src/qsrpd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsrpd_checker: port-level checks of the presence detector
// result consistency and output hold under backpressure
// ----------------------------------------------------------------------------
module qsrpd_checker (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      rsp_valid,
   input  wire logic                                      rsp_ready,
   input  wire logic                                      rsp_window_done,
   input  wire logic [1:0]                                rsp_event_res,
   input  wire logic [qsrpd_pkg::TIME_W-1:0]              rsp_event_time,
   input  wire logic                                      rsp_present
);

   // events only come from a closed window
   a_event_needs_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != qsrpd_pkg::EV_NONE) |-> rsp_window_done)
      else $error("event without window close");

   // the reported state agrees with the transition just made
   a_event_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != qsrpd_pkg::EV_NONE) |->
         (rsp_present == (rsp_event_res == qsrpd_pkg::EV_PRESENT)))
      else $error("event code disagrees with presence");

   // no stamp without an event
   a_quiet_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == qsrpd_pkg::EV_NONE) |-> (rsp_event_time == '0))
      else $error("event time set without event");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_present) &&
         $stable(rsp_event_res) && $stable(rsp_event_time))
      else $error("result changed while stalled");

endmodule

bind quorum_slot_rssi_presence_detector_top qsrpd_checker u_qsrpd_checker (.*);
`default_nettype wire
